// File: src/knn_pkg.sv
package knn_pkg;

    localparam int FEATURES   = 1024;
    localparam int IDX_W      = 10;
    localparam int VAL_W      = 16;
    localparam int CLASS_W    = 7;
    localparam int MAX_K      = 16;
    localparam int K_W        = 5;
    localparam int DIST_W     = 48;
    localparam int TERM_W     = 32;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int OUT_W      = CLASS_W + 1;

    localparam logic [1:0] KIND_WEIGHT = 2'd0;
    localparam logic [1:0] KIND_QUERY  = 2'd1;
    localparam logic [1:0] KIND_POINT  = 2'd2;

    localparam logic CFG_NEIGHBOURS = 1'b0;
    localparam logic CFG_OPEN_CLASS = 1'b1;

    localparam logic [K_W-1:0]     K_RESET    = K_W'(5);
    localparam logic [CLASS_W-1:0] OPEN_RESET = CLASS_W'(100);
    localparam logic [DIST_W-1:0]  DIST_MAX   = {DIST_W{1'b1}};

    // One slot of the sorted neighbor list.
    typedef struct packed {
        logic               valid;
        logic [DIST_W-1:0]  distance;
        logic [CLASS_W-1:0] cls;
    } knn_entry_t;

    // A finished point broadcast to every cell of the list.
    typedef struct packed {
        logic               valid;
        logic               last_set;
        logic [DIST_W-1:0]  distance;
        logic [CLASS_W-1:0] cls;
    } knn_ins_t;

endpackage

// File: src/knn_ram.sv
module knn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/knn_cell.sv
module knn_cell
    import knn_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  knn_ins_t   ins,
    input  knn_entry_t left_entry,
    input  logic       left_hit,
    output knn_entry_t entry,
    output knn_entry_t entry_next,
    output logic       hit
);

    knn_entry_t entry_reg;

    // An empty slot takes any distance; on equal distances the stored point stays ahead.
    assign hit = !entry_reg.valid || (ins.distance < entry_reg.distance);

    always_comb begin
        entry_next = entry_reg;
        if (ins.valid) begin
            if (left_hit) begin
                entry_next = left_entry;
            end else if (hit) begin
                entry_next.valid    = 1'b1;
                entry_next.distance = ins.distance;
                entry_next.cls      = ins.cls;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg.valid <= 1'b0;
        end else if (ins.valid && ins.last_set) begin
            entry_reg.valid <= 1'b0;
        end else begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;

endmodule

// File: src/knn_fifo.sv
module knn_fifo
    import knn_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_en,
    input  logic [OUT_W-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [OUT_W-1:0] rd_data
);

    logic [OUT_W-1:0]   buf_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg;
    logic               rd_fire;

    assign rd_valid = (count_reg != '0);
    assign rd_fire  = rd_valid && rd_ready;
    assign rd_data  = buf_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            buf_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (wr_en) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_fire) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (wr_en && !rd_fire) begin
                count_reg <= count_reg + 1'b1;
            end else if (!wr_en && rd_fire) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: src/weighted_l1_knn_consensus_classifier.sv
// Weighted L1 nearest-neighbor classifier with a consensus vote.
// Input stream (s_): one item per transfer. tuser selects the item kind (weight load,
// query feature load, training feature) and carries the missing flag; tlast marks the
// final feature of the final training point. Weights and query features go into two
// 1024-entry RAMs; training features are scored against them as they stream past.
// Result stream (m_): one transfer per training set, sent after the item that carries
// tlast: the predicted class in tdata and the consensus flag in tuser.
// Throughput is one input item per cycle while s_tready is high, with no bubbles, including
// point and set boundaries: the sorted list is a row of cells that all insert in the same cycle.
// From the tlast transfer, the result passes the RAM read, multiply, accumulate, and
// list insert and vote stages before it reaches the output queue and m_tvalid.
// Results wait in an 8-entry output queue. s_tready drops while 8 results are either
// queued or still inside the pipeline, so a stalled receiver stalls the input side
// and nothing is lost. Items that produce no result are never held back otherwise.
// Reset (aresetn low, synchronous) empties the list, the running distance and the
// queue and sets k to 5 and the open class to 100; the RAM contents are not cleared
// and must be loaded before use. Configuration writes through cfg_we must be made
// only while the block is idle.
module weighted_l1_knn_consensus_classifier
    import knn_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [0:0]   cfg_index,
    input  logic [6:0]   cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // feature_index[9:0], sample_value[25:10], point_class[32:26], last_of_point[33]
    input  logic [39:0]  s_tdata,
    // kind[1:0], missing[2]
    input  logic [2:0]   s_tuser,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // predicted_class[6:0]
    output logic [7:0]   m_tdata,
    // consensus[0]
    output logic [0:0]   m_tuser
);

    // Input fields.
    logic [1:0]         in_kind;
    logic [IDX_W-1:0]   in_idx;
    logic [VAL_W-1:0]   in_val;
    logic               in_miss;
    logic [CLASS_W-1:0] in_cls;
    logic               in_lastp;
    logic               s_fire;

    assign in_kind  = s_tuser[1:0];
    assign in_miss  = s_tuser[2];
    assign in_idx   = s_tdata[9:0];
    assign in_val   = s_tdata[25:10];
    assign in_cls   = s_tdata[32:26];
    assign in_lastp = s_tdata[33];
    assign s_fire   = s_tvalid && s_tready;

    // Configuration.
    logic [K_W-1:0]     k_reg;
    logic [CLASS_W-1:0] open_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg    <= K_RESET;
            open_reg <= OPEN_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index[0])
                CFG_NEIGHBOURS: k_reg    <= cfg_wdata[K_W-1:0];
                CFG_OPEN_CLASS: open_reg <= cfg_wdata[CLASS_W-1:0];
                default:        k_reg    <= k_reg;
            endcase
        end
    end

    // Weight and query stores.
    logic [VAL_W-1:0] w_rdata;
    logic [VAL_W:0]   q_rdata;

    knn_ram #(.WIDTH(VAL_W), .DEPTH(FEATURES)) u_weight_ram (
        .aclk  (aclk),
        .we    (s_fire && (in_kind == KIND_WEIGHT)),
        .waddr (in_idx),
        .wdata (in_val),
        .raddr (in_idx),
        .rdata (w_rdata)
    );

    knn_ram #(.WIDTH(VAL_W + 1), .DEPTH(FEATURES)) u_query_ram (
        .aclk  (aclk),
        .we    (s_fire && (in_kind == KIND_QUERY)),
        .waddr (in_idx),
        .wdata ({in_miss, in_val}),
        .raddr (in_idx),
        .rdata (q_rdata)
    );

    // Stage 1: training item alongside the store read.
    logic               p1_valid_reg;
    logic [VAL_W-1:0]   p1_val_reg;
    logic               p1_miss_reg;
    logic [CLASS_W-1:0] p1_cls_reg;
    logic               p1_lastp_reg;
    logic               p1_lasts_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= s_fire && (in_kind == KIND_POINT);
        end
        p1_val_reg   <= in_val;
        p1_miss_reg  <= in_miss;
        p1_cls_reg   <= in_cls;
        p1_lastp_reg <= in_lastp;
        p1_lasts_reg <= s_tlast;
    end

    // Stage 2: weighted absolute difference.
    logic [VAL_W-1:0]   diff;
    logic               counted;
    logic               p2_valid_reg;
    logic [TERM_W-1:0]  p2_term_reg;
    logic [CLASS_W-1:0] p2_cls_reg;
    logic               p2_end_reg;
    logic               p2_lasts_reg;

    assign diff    = (q_rdata[VAL_W-1:0] > p1_val_reg) ? (q_rdata[VAL_W-1:0] - p1_val_reg)
                                                       : (p1_val_reg - q_rdata[VAL_W-1:0]);
    assign counted = !p1_miss_reg && !q_rdata[VAL_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else begin
            p2_valid_reg <= p1_valid_reg;
        end
        p2_term_reg  <= counted ? (TERM_W'(w_rdata) * TERM_W'(diff)) : '0;
        p2_cls_reg   <= p1_cls_reg;
        p2_end_reg   <= p1_lastp_reg || p1_lasts_reg;
        p2_lasts_reg <= p1_lasts_reg;
    end

    // Stage 3: saturating accumulation of the point's distance.
    logic [DIST_W:0]    sum_wide;
    logic [DIST_W-1:0]  sum_sat;
    logic [DIST_W-1:0]  sum_reg;
    knn_ins_t           ins_reg;

    assign sum_wide = {1'b0, sum_reg} + (DIST_W + 1)'(p2_term_reg);
    assign sum_sat  = sum_wide[DIST_W] ? DIST_MAX : sum_wide[DIST_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg       <= '0;
            ins_reg.valid <= 1'b0;
        end else begin
            if (p2_valid_reg) begin
                sum_reg <= p2_end_reg ? '0 : sum_sat;
            end
            ins_reg.valid <= p2_valid_reg && p2_end_reg;
        end
        ins_reg.last_set <= p2_lasts_reg;
        ins_reg.distance <= sum_sat;
        ins_reg.cls      <= p2_cls_reg;
    end

    // Stage 4: sorted list of the nearest points, one cell per slot.
    knn_entry_t cur  [MAX_K];
    knn_entry_t nx   [MAX_K];
    logic       hit  [MAX_K];
    logic       ok   [MAX_K];
    logic [K_W-1:0] k_eff;

    assign k_eff = (k_reg == '0) ? K_W'(1) : ((k_reg > K_W'(MAX_K)) ? K_W'(MAX_K) : k_reg);

    for (genvar i = 0; i < MAX_K; i++) begin : g_cell
        if (i == 0) begin : g_head
            knn_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ins        (ins_reg),
                .left_entry ('0),
                .left_hit   (1'b0),
                .entry      (cur[i]),
                .entry_next (nx[i]),
                .hit        (hit[i])
            );
        end else begin : g_body
            knn_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ins        (ins_reg),
                .left_entry (cur[i-1]),
                .left_hit   (hit[i-1]),
                .entry      (cur[i]),
                .entry_next (nx[i]),
                .hit        (hit[i])
            );
        end
        // Slots beyond k do not vote; slots within k must be filled and match the head.
        assign ok[i] = (K_W'(i) >= k_eff) || (nx[i].valid && (nx[i].cls == nx[0].cls));
    end

    logic agree;

    always_comb begin
        agree = 1'b1;
        for (int i = 0; i < MAX_K; i++) begin
            agree = agree && ok[i];
        end
    end

    // Result queue and credit count of results queued or in flight.
    logic [OUT_W-1:0] res_data;
    logic [OUT_W-1:0] q_out;
    logic [FIFO_AW:0] pend_reg;
    logic             pend_inc;
    logic             pend_dec;

    assign res_data = {agree, (agree ? nx[0].cls : open_reg)};

    knn_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (ins_reg.valid && ins_reg.last_set),
        .wr_data  (res_data),
        .rd_valid (m_tvalid),
        .rd_ready (m_tready),
        .rd_data  (q_out)
    );

    assign pend_inc = s_fire && (in_kind == KIND_POINT) && s_tlast;
    assign pend_dec = m_tvalid && m_tready;
    assign s_tready = (pend_reg < (FIFO_AW + 1)'(FIFO_DEPTH));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else if (pend_inc && !pend_dec) begin
            pend_reg <= pend_reg + 1'b1;
        end else if (!pend_inc && pend_dec) begin
            pend_reg <= pend_reg - 1'b1;
        end
    end

    assign m_tdata = {1'b0, q_out[CLASS_W-1:0]};
    assign m_tuser = q_out[CLASS_W];

endmodule
